FILE: rtl/asalu_pkg.sv
`timescale 1ns / 1ps
// Package for the ARM register-shifted ALU: field types, opcodes, shift codes.
package asalu_pkg;

  localparam int unsigned XLEN = 32;

  // Data-processing opcodes
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_ADC = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_RSC = 4'd7;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;
  localparam logic [3:0] OP_MVN = 4'd15;

  // Shift types
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  typedef struct packed {
    logic [3:0]      opcode;
    logic [1:0]      shift_type;
    logic            set_flags;
    logic [XLEN-1:0] first_operand;
    logic [XLEN-1:0] shifted_operand;
    logic [7:0]      shift_amount;
    logic            carry_flag;
    logic            overflow_in;
    logic [3:0]      dest_reg;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            write_back;
    logic [3:0]      dest_index;
    logic            flags_written;
    logic            flag_n;
    logic            flag_z;
    logic            flag_c;
    logic            flag_v;
  } out_item_t;

  // Shifter result handed to the ALU
  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            carry;
  } shift_res_t;

endpackage

FILE: rtl/asalu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction and result transactions.
interface asalu_in_if;
  logic                 valid;
  logic                 ready;
  asalu_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asalu_out_if;
  logic                 valid;
  logic                 ready;
  asalu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/asalu_shifter.sv
`timescale 1ns / 1ps
// Barrel shifter with ARM register-shift carry rules.
module asalu_shifter (
  input  logic [1:0]                       shift_type,
  input  logic [asalu_pkg::XLEN-1:0]       operand,
  input  logic [7:0]                       amount,
  input  logic                             carry_flag,
  output asalu_pkg::shift_res_t            shifted
);

  logic [4:0]                    amt_lo;
  logic                          amt_big;   // amount >= 32
  logic                          amt_32;
  logic [asalu_pkg::XLEN:0]      lsl_w;
  logic [asalu_pkg::XLEN:0]      lsr_w;
  logic [asalu_pkg::XLEN:0]      asr_w;
  logic [2*asalu_pkg::XLEN-1:0]  ror_w;
  logic [asalu_pkg::XLEN-1:0]    ror_v;

  assign amt_lo  = amount[4:0];
  assign amt_big = |amount[7:5];
  assign amt_32  = (amount[7:5] == 3'b001) && (amt_lo == 5'd0);

  // Extra bit catches the last bit shifted out
  assign lsl_w = {1'b0, operand} << amt_lo;
  assign lsr_w = {operand, 1'b0} >> amt_lo;
  assign asr_w = $unsigned($signed({operand, 1'b0}) >>> amt_lo);
  assign ror_w = {operand, operand} >> amt_lo;
  assign ror_v = ror_w[asalu_pkg::XLEN-1:0];

  always_comb begin
    shifted.value = operand;
    shifted.carry = carry_flag;
    if (amount != 8'd0) begin
      case (shift_type)
        asalu_pkg::SH_LSL: begin
          if (!amt_big) begin
            shifted.value = lsl_w[asalu_pkg::XLEN-1:0];
            shifted.carry = lsl_w[asalu_pkg::XLEN];
          end else begin
            shifted.value = '0;
            shifted.carry = amt_32 & operand[0];
          end
        end
        asalu_pkg::SH_LSR: begin
          if (!amt_big) begin
            shifted.value = lsr_w[asalu_pkg::XLEN:1];
            shifted.carry = lsr_w[0];
          end else begin
            shifted.value = '0;
            shifted.carry = amt_32 & operand[asalu_pkg::XLEN-1];
          end
        end
        asalu_pkg::SH_ASR: begin
          if (!amt_big) begin
            shifted.value = asr_w[asalu_pkg::XLEN:1];
            shifted.carry = asr_w[0];
          end else begin
            shifted.value = {asalu_pkg::XLEN{operand[asalu_pkg::XLEN-1]}};
            shifted.carry = operand[asalu_pkg::XLEN-1];
          end
        end
        default: begin
          // ROR uses amount mod 32; zero rotation keeps value, carry = msb
          shifted.value = ror_v;
          shifted.carry = ror_v[asalu_pkg::XLEN-1];
        end
      endcase
    end
  end

endmodule

FILE: rtl/asalu_exec.sv
`timescale 1ns / 1ps
// Opcode decode, logic unit, AddWithCarry adder and NZCV generation.
module asalu_exec (
  input  asalu_pkg::in_item_t   item,
  input  asalu_pkg::shift_res_t shifted,
  output asalu_pkg::out_item_t  res
);

  localparam int unsigned W = asalu_pkg::XLEN;

  logic [W-1:0] rn;
  logic [W-1:0] sh;
  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic         add_c;
  logic [W:0]   sum;
  logic         arith;
  logic         add_v;
  logic [W-1:0] value;
  logic         c_flag;
  logic         v_flag;

  assign rn = item.first_operand;
  assign sh = shifted.value;

  // Operand steering for the single adder
  always_comb begin
    add_a = rn;
    add_b = sh;
    add_c = 1'b0;
    arith = 1'b1;
    case (item.opcode)
      asalu_pkg::OP_SUB, asalu_pkg::OP_CMP: begin
        add_b = ~sh;
        add_c = 1'b1;
      end
      asalu_pkg::OP_RSB: begin
        add_a = ~rn;
        add_c = 1'b1;
      end
      asalu_pkg::OP_ADD, asalu_pkg::OP_CMN: begin
        add_c = 1'b0;
      end
      asalu_pkg::OP_ADC: begin
        add_c = item.carry_flag;
      end
      asalu_pkg::OP_SBC: begin
        add_b = ~sh;
        add_c = item.carry_flag;
      end
      asalu_pkg::OP_RSC: begin
        add_a = ~rn;
        add_c = item.carry_flag;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_c};
  assign add_v = (~(add_a[W-1] ^ add_b[W-1])) & (add_a[W-1] ^ sum[W-1]);

  always_comb begin
    case (item.opcode)
      asalu_pkg::OP_AND, asalu_pkg::OP_TST: value = rn & sh;
      asalu_pkg::OP_EOR, asalu_pkg::OP_TEQ: value = rn ^ sh;
      asalu_pkg::OP_ORR:                    value = rn | sh;
      asalu_pkg::OP_MOV:                    value = sh;
      asalu_pkg::OP_BIC:                    value = rn & ~sh;
      asalu_pkg::OP_MVN:                    value = ~sh;
      default:                              value = sum[W-1:0];
    endcase
  end

  assign c_flag = arith ? sum[W] : shifted.carry;
  assign v_flag = arith ? add_v  : item.overflow_in;

  always_comb begin
    res.result        = value;
    res.write_back    = !(item.opcode inside {[asalu_pkg::OP_TST:asalu_pkg::OP_CMN]});
    res.dest_index    = item.dest_reg;
    res.flags_written = item.set_flags;
    res.flag_n        = item.set_flags & value[W-1];
    res.flag_z        = item.set_flags & (value == '0);
    res.flag_c        = item.set_flags & c_flag;
    res.flag_v        = item.set_flags & v_flag;
  end

endmodule

FILE: rtl/arm_register_shifted_alu_unit.sv
`timescale 1ns / 1ps
// Top level: ARM data-processing ALU with register-shifted second operand.
//
//   channel  modport  transaction
//   -------  -------  ------------------------------------------------
//   cmd      sink     one instruction: opcode, shift, operands, C/V, Rd
//   rsp      source   one result: value, write-back, Rd, NZCV
//
// Two register stages: an input register, then shifter + ALU logic into a
// result register. An accepted cmd transaction is captured in the input register,
// and its result in the result register, which drives rsp.valid. Throughput is one
// instruction per cycle unless rsp stalls, set by the single shifter/adder pass.
// rst (synchronous) clears both stage valid bits; payload registers are not reset.
// A stall on rsp holds the result register; cmd.ready drops only when both
// stages are full, so the input register acts as the skid slot.
module arm_register_shifted_alu_unit (
  input logic         clk,
  input logic         rst,
  asalu_in_if.sink    cmd,
  asalu_out_if.source rsp
);

  logic                  s1_valid;
  asalu_pkg::in_item_t   s1_item;
  logic                  out_valid;
  asalu_pkg::out_item_t  out_item;

  logic                  out_free;
  logic                  s1_load;
  asalu_pkg::shift_res_t shifted;
  asalu_pkg::out_item_t  exec_res;

  // Result slot empties when not holding, or when being taken this cycle
  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = !s1_valid || out_free;
  assign s1_load   = cmd.valid && cmd.ready;

  asalu_shifter u_shifter (
    .shift_type (s1_item.shift_type),
    .operand    (s1_item.shifted_operand),
    .amount     (s1_item.shift_amount),
    .carry_flag (s1_item.carry_flag),
    .shifted    (shifted)
  );

  asalu_exec u_exec (
    .item    (s1_item),
    .shifted (shifted),
    .res     (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_load) begin
      s1_item <= cmd.data;
    end
    if (out_free && s1_valid) begin
      out_item <= exec_res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  // A held instruction keeps its payload until it moves to the result stage
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input stage lost or changed a held instruction");

  // Accepted instruction lands in the input stage
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted instruction not captured");

  // Flags are zero when the S bit is clear
  a_flags_off: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.flags_written |->
      !rsp.data.flag_n && !rsp.data.flag_z && !rsp.data.flag_c && !rsp.data.flag_v)
    else $error("flags set without S bit");

  // N and Z follow the result value
  a_nz: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.flags_written |->
      rsp.data.flag_n == rsp.data.result[asalu_pkg::XLEN-1] &&
      rsp.data.flag_z == (rsp.data.result == '0))
    else $error("N/Z inconsistent with result");

endmodule
